/* rtl/assert_macros.svh */
// Assertion macros shared by the parser and result register modules of the UUID matcher.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Implication that must hold in the same cycle.
`define UAM_ASSERT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Implication whose consequent must hold in the cycle after the antecedent.
`define UAM_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define UAM_ASSERT(name, ante, cons, msg)
`define UAM_ASSERT_NEXT(name, ante, cons, msg)
`endif
`endif

/* rtl/uam_pkg.sv */
// Types and constants of the advertising data UUID matcher.
package uam_pkg;

    typedef enum logic [1:0] {
        PH_LEN  = 2'd0,
        PH_TYPE = 2'd1,
        PH_DATA = 2'd2,
        PH_STOP = 2'd3
    } uam_phase_t;

    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_16   = 2'd1,
        KIND_128  = 2'd2
    } uam_kind_t;

    localparam int unsigned CFG_INDEX_W = 4;
    localparam int unsigned CFG_DATA_W  = 64;

    localparam logic [CFG_INDEX_W-1:0] REG_TARGET_HIGH = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_TARGET_LOW  = 4'd1;

    localparam logic [7:0] AD_TYPE_UUID16_PART  = 8'h02;
    localparam logic [7:0] AD_TYPE_UUID16_FULL  = 8'h03;
    localparam logic [7:0] AD_TYPE_UUID128_PART = 8'h06;
    localparam logic [7:0] AD_TYPE_UUID128_FULL = 8'h07;

    localparam logic [3:0] UUID128_LAST_POS = 4'd15;

    // Bluetooth base UUID 0000xxxx-0000-1000-8000-00805F9B34FB.
    localparam logic [63:0] BASE_HIGH_MASK = 64'hFFFF_0000_FFFF_FFFF;
    localparam logic [63:0] BASE_HIGH_BITS = 64'h0000_0000_0000_1000;
    localparam logic [63:0] BASE_LOW_BITS  = 64'h8000_0080_5F9B_34FB;

    typedef struct packed {
        logic valid;
        logic found;
    } uam_result_t;

endpackage

/* rtl/uam_parser.sv */
// Structure parser and UUID entry comparator, one advertising byte per transaction.
`include "assert_macros.svh"
module uam_parser
    import uam_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    input  logic [63:0] target_high,
    input  logic [63:0] target_low,
    output uam_result_t result
);

    uam_phase_t phase_reg, phase_next;
    logic [7:0] left_reg, left_next;
    uam_kind_t  kind_reg, kind_next;
    logic [3:0] pos_reg, pos_next;
    logic       equal_reg, equal_next;
    logic       pending_reg, pending_next;
    logic       committed_reg, committed_next;
    logic       found_now;

    logic [127:0] target_uuid;
    logic         base_form;
    logic [7:0]   want_byte;
    logic         byte_equal;
    logic         entry_done;

    assign target_uuid = {target_high, target_low};
    assign base_form   = ((target_high & BASE_HIGH_MASK) == BASE_HIGH_BITS)
                         && (target_low == BASE_LOW_BITS);

    // Entries are little-endian, so entry byte p meets UUID byte 15-p in a 128-bit list and 3-p in a 16-bit list.
    always_comb
    begin
        if (kind_reg == KIND_16)
        begin
            want_byte = pos_reg[0] ? target_high[47:40] : target_high[39:32];
        end
        else
        begin
            want_byte = target_uuid[{pos_reg, 3'b000} +: 8];
        end
    end

    assign byte_equal = (data_byte == want_byte);
    assign entry_done = (kind_reg == KIND_16) ? pos_reg[0] : (pos_reg == UUID128_LAST_POS);

    always_comb
    begin
        phase_next     = phase_reg;
        left_next      = left_reg;
        kind_next      = kind_reg;
        pos_next       = pos_reg;
        equal_next     = equal_reg;
        pending_next   = pending_reg;
        committed_next = committed_reg;
        found_now      = 1'b0;
        if (step)
        begin
            unique case (phase_reg)
                PH_LEN:
                begin
                    if (data_byte == 8'd0)
                    begin
                        phase_next = PH_STOP;
                    end
                    else
                    begin
                        left_next  = data_byte;
                        phase_next = PH_TYPE;
                    end
                end
                PH_TYPE:
                begin
                    case (data_byte)
                        AD_TYPE_UUID16_PART, AD_TYPE_UUID16_FULL:   kind_next = KIND_16;
                        AD_TYPE_UUID128_PART, AD_TYPE_UUID128_FULL: kind_next = KIND_128;
                        default:                                    kind_next = KIND_NONE;
                    endcase
                    pos_next     = 4'd0;
                    equal_next   = 1'b1;
                    pending_next = 1'b0;
                    left_next    = left_reg - 8'd1;
                    phase_next   = PH_DATA;
                end
                PH_DATA:
                begin
                    if (kind_reg != KIND_NONE)
                    begin
                        if (entry_done)
                        begin
                            if (equal_reg && byte_equal && (kind_reg == KIND_128 || base_form))
                            begin
                                pending_next = 1'b1;
                            end
                            pos_next   = 4'd0;
                            equal_next = 1'b1;
                        end
                        else
                        begin
                            pos_next   = pos_reg + 4'd1;
                            equal_next = equal_reg && byte_equal;
                        end
                    end
                    left_next = left_reg - 8'd1;
                end
                default:
                begin
                end
            endcase

            // A match counts once the structure's final byte is inside the buffer.
            if (phase_next == PH_DATA && left_next == 8'd0)
            begin
                if (pending_next)
                begin
                    committed_next = 1'b1;
                end
                pending_next = 1'b0;
                kind_next    = KIND_NONE;
                pos_next     = 4'd0;
                equal_next   = 1'b1;
                phase_next   = PH_LEN;
            end

            if (last_byte)
            begin
                found_now      = committed_next;
                phase_next     = PH_LEN;
                left_next      = 8'd0;
                kind_next      = KIND_NONE;
                pos_next       = 4'd0;
                equal_next     = 1'b1;
                pending_next   = 1'b0;
                committed_next = 1'b0;
            end
        end
    end

    always_comb
    begin
        result.valid = step && last_byte;
        result.found = found_now;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_LEN;
            left_reg      <= 8'd0;
            kind_reg      <= KIND_NONE;
            pos_reg       <= 4'd0;
            equal_reg     <= 1'b1;
            pending_reg   <= 1'b0;
            committed_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            left_reg      <= left_next;
            kind_reg      <= kind_next;
            pos_reg       <= pos_next;
            equal_reg     <= equal_next;
            pending_reg   <= pending_next;
            committed_reg <= committed_next;
        end
    end

    `UAM_ASSERT_NEXT(a_clear_after_last, step && last_byte,
        phase_reg == PH_LEN && !committed_reg && !pending_reg, "state not cleared after last byte")
    `UAM_ASSERT(a_pending_in_list, pending_reg, kind_reg != KIND_NONE,
        "pending match outside a UUID list")
    `UAM_ASSERT(a_pos16_range, kind_reg == KIND_16, pos_reg == 4'd0 || pos_reg == 4'd1,
        "16-bit entry position out of range")
    `UAM_ASSERT(a_kind_only_in_data, kind_reg != KIND_NONE, phase_reg == PH_DATA,
        "list kind set outside data phase")

endmodule

/* rtl/uam_out_reg.sv */
// Result register that holds one match report until the receiver takes it.
`include "assert_macros.svh"
module uam_out_reg
    import uam_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  uam_result_t result,
    output logic        can_load,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        uuid_found
);

    logic valid_reg, valid_next;
    logic found_reg, found_next;

    assign can_load = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = valid_reg;
        found_next = found_reg;
        if (out_ready)
        begin
            valid_next = 1'b0;
        end
        if (result.valid)
        begin
            valid_next = 1'b1;
            found_next = result.found;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        found_reg <= found_next;
    end

    assign out_valid  = valid_reg;
    assign uuid_found = found_reg;

    `UAM_ASSERT(a_no_overwrite, result.valid, can_load, "result register overwritten")
    `UAM_ASSERT_NEXT(a_load_shows, result.valid, valid_reg, "loaded result not shown")
    `UAM_ASSERT_NEXT(a_drain_empties, out_ready && !result.valid, !valid_reg,
        "result register did not drain")

endmodule

/* rtl/adv_data_uuid_matcher_top.sv */
// Top level of the advertising data service UUID matcher.
// Usage:
//   The input channel (in_valid/in_ready, data_byte, last_byte) carries one
//   advertising data byte per transaction; last_byte marks the buffer's end.
//   The output channel (out_valid/out_ready, uuid_found) carries one
//   transaction per buffer, issued for its final byte, telling whether a
//   complete 16-bit or 128-bit service UUID list held the target UUID.
//   The target UUID is written through cfg_we/cfg_index/cfg_data: index 0 is
//   the upper 64 bits, index 1 the lower 64 bits; other indexes are ignored.
//   Write it only while no buffer is in progress.
//   Throughput is one byte per cycle while in_ready is high; the parser updates
//   its state in the cycle a byte is taken, and the report appears in the cycle
//   after the final byte is accepted, held in a single result register.
//   While that register holds an unread report and out_ready is low, in_ready
//   drops, so a stalled receiver stalls the byte stream.
//   Reset clears the parser state and the target UUID to zero; no
//   report is pending after reset.
module adv_data_uuid_matcher_top
    import uam_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [7:0]             data_byte,
    input  logic                   last_byte,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic                   uuid_found,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    logic [63:0] target_high_reg;
    logic [63:0] target_low_reg;
    logic        step;
    logic        can_load;
    uam_result_t result;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_high_reg <= 64'd0;
            target_low_reg  <= 64'd0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_TARGET_HIGH: target_high_reg <= cfg_data;
                REG_TARGET_LOW:  target_low_reg  <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    assign in_ready = can_load;
    assign step     = in_valid && can_load;

    uam_parser u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .data_byte   (data_byte),
        .last_byte   (last_byte),
        .target_high (target_high_reg),
        .target_low  (target_low_reg),
        .result      (result)
    );

    uam_out_reg u_out_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .result     (result),
        .can_load   (can_load),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .uuid_found (uuid_found)
    );

endmodule

/* verif/tb.sv */
// Self-checking testbench of the advertising data service UUID matcher.
module tb;
    import uam_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 200000;
    localparam logic [7:0] AD_TYPE_NAME = 8'h09;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_ready;
    logic [7:0]             data_byte = 8'h00;
    logic                   last_byte = 1'b0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    logic                   uuid_found;
    logic                   cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    // Mirror of the target registers and of the parser state.
    logic [63:0] target_hi = '0;
    logic [63:0] target_lo = '0;
    uam_phase_t  phase;
    logic [7:0]  remain;
    uam_kind_t   kind;
    logic [3:0]  entry_pos;
    logic        entry_eq;
    logic        match_pending;
    logic        match_committed;

    logic        found_q[$];
    logic [7:0]  ad_buf[$];
    logic        want_found;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int cycle_count = 0;
    int error_count = 0;
    int bytes_sent = 0;
    int buffers_sent = 0;
    int targets_loaded = 0;
    int reports_checked = 0;
    int reports_found = 0;

    adv_data_uuid_matcher_top u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .data_byte  (data_byte),
        .last_byte  (last_byte),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .uuid_found (uuid_found),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d reports outstanding", $time, found_q.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Every report transaction is matched against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            reports_checked++;
            if (found_q.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected report, expected none, actual uuid_found=%0b",
                         $time, uuid_found);
            end
            else
            begin
                want_found = found_q.pop_front();
                if (uuid_found !== want_found)
                begin
                    error_count++;
                    $display("%0t: uuid_found mismatch, expected %0b, actual %0b",
                             $time, want_found, uuid_found);
                end
            end
        end
    end

    function automatic void reset_parser();
        phase = PH_LEN;
        remain = 8'd0;
        kind = KIND_NONE;
        entry_pos = 4'd0;
        entry_eq = 1'b1;
        match_pending = 1'b0;
        match_committed = 1'b0;
    endfunction

    // Byte k of the target UUID, counted from the most significant end.
    function automatic logic [7:0] tgt_byte(input int unsigned k);
        logic [127:0] whole;
        whole = {target_hi, target_lo};
        return whole[127 - 8 * k -: 8];
    endfunction

    // Advances the parser by one byte; returns 1 when a report is due.
    function automatic bit parse_byte(input logic [7:0] b, input logic lst,
                                      output logic found);
        int unsigned entry_len;
        logic [7:0]  want;
        logic        base;
        found = 1'b0;
        base = ((target_hi & BASE_HIGH_MASK) == BASE_HIGH_BITS) &&
               (target_lo == BASE_LOW_BITS);
        case (phase)
            PH_LEN:
            begin
                if (b == 8'd0)
                    phase = PH_STOP;
                else
                begin
                    remain = b;
                    phase = PH_TYPE;
                end
            end
            PH_TYPE:
            begin
                if (b == AD_TYPE_UUID16_PART || b == AD_TYPE_UUID16_FULL)
                    kind = KIND_16;
                else if (b == AD_TYPE_UUID128_PART || b == AD_TYPE_UUID128_FULL)
                    kind = KIND_128;
                else
                    kind = KIND_NONE;
                entry_pos = 4'd0;
                entry_eq = 1'b1;
                match_pending = 1'b0;
                remain = remain - 8'd1;
                phase = PH_DATA;
            end
            PH_DATA:
            begin
                if (kind != KIND_NONE)
                begin
                    entry_len = (kind == KIND_16) ? 2 : 16;
                    // Entries arrive little-endian, so the last UUID byte comes first.
                    want = (kind == KIND_16) ? tgt_byte(3 - entry_pos[0])
                                             : tgt_byte(15 - entry_pos);
                    if (b != want)
                        entry_eq = 1'b0;
                    if (entry_pos == 4'(entry_len - 1))
                    begin
                        if (entry_eq && (kind == KIND_128 || base))
                            match_pending = 1'b1;
                        entry_pos = 4'd0;
                        entry_eq = 1'b1;
                    end
                    else
                        entry_pos = entry_pos + 4'd1;
                end
                remain = remain - 8'd1;
            end
            default:
                ;
        endcase
        if (phase == PH_DATA && remain == 8'd0)
        begin
            if (match_pending)
                match_committed = 1'b1;
            match_pending = 1'b0;
            kind = KIND_NONE;
            entry_pos = 4'd0;
            entry_eq = 1'b1;
            phase = PH_LEN;
        end
        if (!lst)
            return 1'b0;
        found = match_committed;
        reset_parser();
        return 1'b1;
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic lst);
        logic found_bit;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        data_byte <= b;
        last_byte <= lst;
        do
            @(posedge clk);
        while (!in_ready);
        bytes_sent++;
        if (parse_byte(b, lst, found_bit))
        begin
            found_q.push_back(found_bit);
            if (found_bit)
                reports_found++;
        end
    endtask

    task automatic send_buffer();
        foreach (ad_buf[i])
            send_byte(ad_buf[i], i == ad_buf.size() - 1);
        ad_buf.delete();
        buffers_sent++;
    endtask

    // Holds the byte stream until every pending report has been read.
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (found_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx, input logic [63:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        if (idx == REG_TARGET_HIGH)
            target_hi = val;
        else if (idx == REG_TARGET_LOW)
            target_lo = val;
    endtask

    task automatic set_target(input logic [63:0] hi, input logic [63:0] lo);
        cfg_write(REG_TARGET_HIGH, hi);
        cfg_write(REG_TARGET_LOW, lo);
        targets_loaded++;
    endtask

    task automatic pick_target();
        logic [63:0]            hi;
        logic [63:0]            lo;
        logic [CFG_INDEX_W-1:0] spare;
        case ($urandom_range(5))
            0:
            begin
                hi = BASE_HIGH_BITS | {16'h0000, 16'($urandom), 32'h0};
                lo = BASE_LOW_BITS;
            end
            1:
            begin
                // Nonzero top bits keep it out of the base UUID form.
                hi = BASE_HIGH_BITS | {16'($urandom_range(1, 65535)), 16'($urandom), 32'h0};
                lo = BASE_LOW_BITS;
            end
            2:
            begin
                hi = '1;
                lo = '1;
            end
            3:
            begin
                hi = '0;
                lo = '0;
            end
            default:
            begin
                hi = {$urandom, $urandom};
                lo = {$urandom, $urandom};
            end
        endcase
        set_target(hi, lo);
        if ($urandom_range(2) == 0)
        begin
            spare = CFG_INDEX_W'($urandom_range(2, (1 << CFG_INDEX_W) - 1));
            cfg_write(spare, {$urandom, $urandom});
        end
    endtask

    // Appends one list entry: the target, the target with one bit flipped, or noise.
    function automatic void push_entry(input bit wide);
        int unsigned entry_len;
        int unsigned pick;
        int unsigned flip;
        logic [7:0]  b;
        entry_len = wide ? 16 : 2;
        pick = $urandom_range(9);
        flip = $urandom_range(entry_len - 1);
        for (int i = 0; i < entry_len; i++)
        begin
            b = wide ? tgt_byte(15 - i) : tgt_byte(3 - i);
            if (pick < 3)
                b = 8'($urandom);
            else if (pick < 5 && i == flip)
                b = b ^ 8'(1 << $urandom_range(7));
            ad_buf.push_back(b);
        end
    endfunction

    function automatic void push_list(input bit wide);
        int unsigned entry_len;
        int unsigned n_entry;
        int unsigned extra;
        entry_len = wide ? 16 : 2;
        n_entry = wide ? $urandom_range(0, 2) : $urandom_range(0, 4);
        extra = ($urandom_range(3) == 0) ? $urandom_range(1, entry_len - 1) : 0;
        ad_buf.push_back(8'(1 + n_entry * entry_len + extra));
        if (wide)
            ad_buf.push_back($urandom_range(1) ? AD_TYPE_UUID128_PART : AD_TYPE_UUID128_FULL);
        else
            ad_buf.push_back($urandom_range(1) ? AD_TYPE_UUID16_PART : AD_TYPE_UUID16_FULL);
        repeat (n_entry) push_entry(wide);
        repeat (extra) ad_buf.push_back(8'($urandom));
    endfunction

    function automatic void push_other();
        logic [7:0] len;
        len = ($urandom_range(19) == 0) ? 8'($urandom_range(100, 255))
                                        : 8'($urandom_range(1, 6));
        ad_buf.push_back(len);
        ad_buf.push_back(8'($urandom));
        repeat (len - 8'd1) ad_buf.push_back(8'($urandom));
    endfunction

    function automatic void build_buffer();
        int unsigned n_struct;
        int unsigned pick;
        int unsigned cut;
        if ($urandom_range(9) == 0)
        begin
            repeat ($urandom_range(1, 12)) ad_buf.push_back(8'($urandom));
            return;
        end
        n_struct = $urandom_range(1, 4);
        for (int s = 0; s < n_struct; s++)
        begin
            pick = $urandom_range(99);
            if (pick < 40)
                push_list(1'b0);
            else if (pick < 70)
                push_list(1'b1);
            else if (pick < 92)
                push_other();
            else
            begin
                // Anything after a zero length must be ignored, even a good list.
                ad_buf.push_back(8'h00);
                if ($urandom_range(1))
                    push_list(1'b0);
                break;
            end
        end
        pick = $urandom_range(99);
        if (pick < 15)
        begin
            cut = $urandom_range(1, ad_buf.size());
            while (ad_buf.size() > cut)
                void'(ad_buf.pop_back());
        end
        else if (pick < 20)
            ad_buf.push_back(8'($urandom_range(1, 255)));
    endfunction

    task automatic test_directed();
        send_idle_pct = 18;
        recv_idle_pct = 59;
        set_target(64'h0000_180D_0000_1000, BASE_LOW_BITS);
        ad_buf = '{8'h03, AD_TYPE_UUID16_FULL, 8'h0D, 8'h18};
        send_buffer();
        ad_buf = '{8'h00, 8'h18};
        send_buffer();
        ad_buf = '{8'h04, AD_TYPE_UUID16_PART, 8'h0D, 8'h18, 8'h0D};
        send_buffer();
        ad_buf = '{8'h05, AD_TYPE_UUID16_FULL, 8'h0D, 8'h18};
        send_buffer();
        ad_buf = '{8'hFF};
        send_buffer();
        ad_buf = '{8'h03, AD_TYPE_NAME, 8'h0D, 8'h18};
        send_buffer();
        wait_idle();
        set_target('1, '1);
        cfg_write(CFG_INDEX_W'(15), '0);
        ad_buf = '{8'h11, AD_TYPE_UUID128_PART};
        repeat (16) ad_buf.push_back(8'hFF);
        send_buffer();
        ad_buf = '{8'h03, AD_TYPE_UUID16_FULL, 8'hFF, 8'hFF};
        send_buffer();
        wait_idle();
    endtask

    task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                       input int n_bytes, input int n_bufs);
        int start_bytes;
        int bufs;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        start_bytes = bytes_sent;
        bufs = 0;
        while (bytes_sent - start_bytes < n_bytes || bufs < n_bufs)
        begin
            if (bufs % 8 == 0)
            begin
                wait_idle();
                pick_target();
            end
            else if ($urandom_range(9) == 0)
                wait_idle();
            build_buffer();
            send_buffer();
            bufs++;
        end
    endtask

    initial
    begin
        reset_parser();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random_traffic(18, 59, 230, 8);
        test_random_traffic(59, 18, 230, 8);
        test_random_traffic(0, 0, 230, 8);
        wait_idle();
        $display("Sent %0d bytes in %0d advertising buffers across %0d target UUIDs.",
                 bytes_sent, buffers_sent, targets_loaded);
        $display("Checked %0d reports, %0d of them with the target present.",
                 reports_checked, reports_found);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

/* adv_data_uuid_matcher_top.f */
+incdir+rtl
rtl/uam_pkg.sv
rtl/uam_parser.sv
rtl/uam_out_reg.sv
rtl/adv_data_uuid_matcher_top.sv
verif/tb.sv
